### hw/rtl/mf3_pkg.sv
package mf3_pkg;

  localparam int PIX_W      = 16;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int LW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  // Queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QLVL_W  = 3;

  localparam logic [PIX_W-1:0] PIX_SIGN = PIX_W'(1) << (PIX_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_PIXELS = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             frame_end;
  } out_beat_t;

  typedef struct packed {
    logic [LW_W-1:0] line_width;
    logic [FH_W-1:0] frame_height;
    logic            signed_pixels;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             frame_end;
  } tag_t;

  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    tag_t                  tag;
  } win_item_t;

  typedef struct packed {
    logic              empty;
    logic [QLVL_W-1:0] level;
  } q_status_t;

endpackage

### hw/rtl/mf3_front.sv
module mf3_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mf3_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  input  mf3_pkg::in_beat_t               in_data,
  output logic                            in_stall,
  input  mf3_pkg::q_status_t              q_stat,
  output logic                            q_push,
  output mf3_pkg::win_item_t              q_item
);

  localparam int PW = mf3_pkg::PIX_W;
  localparam int CW = mf3_pkg::COL_W;
  localparam int RW = mf3_pkg::ROW_W;
  localparam int LW = mf3_pkg::LW_W;
  localparam int FW = mf3_pkg::FH_W;
  localparam int QW = mf3_pkg::QLVL_W;

  logic            accept;
  logic [QW-1:0]   credit;

  logic [LW-1:0]   eff_w;
  logic [FW-1:0]   eff_h;
  logic [CW-1:0]   wm1;
  logic [RW-1:0]   hm1;

  logic [CW-1:0]   col_r, col_nxt, col_cur;
  logic [RW-1:0]   row_r, row_nxt, row_cur;
  logic            last_col, last_row;

  logic            s1_v_r;
  logic [PW-1:0]   s1_pix_r;
  logic [CW-1:0]   s1_col_r;
  logic            s1_emit_r;
  mf3_pkg::tag_t   s1_tag_r;

  logic [2*PW-1:0] lstore [mf3_pkg::MAX_WIDTH];
  logic [2*PW-1:0] rd_r;
  logic            fwd_r;
  logic [2*PW-1:0] fwd_data_r;
  logic [2*PW-1:0] rd_eff;
  logic [2*PW-1:0] wr_data;

  logic [8:0][PW-1:0] win_r;
  logic [8:0][PW-1:0] win_nxt;

  // Items in flight in the front stage count against queue space
  assign credit   = QW'(q_stat.level + QW'(s1_v_r));
  assign in_stall = credit >= QW'(mf3_pkg::QDEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (cfg.line_width < LW'(mf3_pkg::MIN_DIM)) begin
      eff_w = LW'(mf3_pkg::MIN_DIM);
    end else if (cfg.line_width > LW'(mf3_pkg::MAX_WIDTH)) begin
      eff_w = LW'(mf3_pkg::MAX_WIDTH);
    end else begin
      eff_w = cfg.line_width;
    end
    if (cfg.frame_height < FW'(mf3_pkg::MIN_DIM)) begin
      eff_h = FW'(mf3_pkg::MIN_DIM);
    end else if (cfg.frame_height > FW'(mf3_pkg::MAX_HEIGHT)) begin
      eff_h = FW'(mf3_pkg::MAX_HEIGHT);
    end else begin
      eff_h = cfg.frame_height;
    end
    wm1 = CW'(eff_w - LW'(1));
    hm1 = RW'(eff_h - FW'(1));
  end

  always_comb begin
    col_cur  = in_data.frame_start ? '0 : col_r;
    row_cur  = in_data.frame_start ? '0 : row_r;
    last_col = col_cur >= wm1;
    last_row = row_cur >= hm1;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : RW'(row_cur + RW'(1));
    end else begin
      col_nxt = CW'(col_cur + CW'(1));
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r            <= in_data.pixel;
      s1_col_r            <= col_cur;
      s1_emit_r           <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
      s1_tag_r.center_row <= RW'(row_cur - RW'(1));
      s1_tag_r.center_col <= CW'(col_cur - CW'(1));
      s1_tag_r.frame_end  <= last_col && last_row;
    end
  end

  // Line stores: upper in the high half, middle in the low half
  assign rd_eff  = fwd_r ? fwd_data_r : rd_r;
  assign wr_data = {rd_eff[PW-1:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r       <= lstore[col_cur];
      // Write of the previous beat lands on this edge: forward it
      fwd_r      <= s1_v_r && (s1_col_r == col_cur);
      fwd_data_r <= wr_data;
    end
    if (s1_v_r) begin
      lstore[s1_col_r] <= wr_data;
    end
  end

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = rd_eff[2*PW-1:PW];
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = rd_eff[PW-1:0];
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      win_r <= win_nxt;
    end
  end

  assign q_push     = s1_v_r && s1_emit_r;
  assign q_item.win = win_nxt;
  assign q_item.tag = s1_tag_r;

endmodule

### hw/rtl/mf3_queue.sv
module mf3_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mf3_pkg::win_item_t   push_item,
  input  logic                 pop,
  output mf3_pkg::win_item_t   head,
  output mf3_pkg::q_status_t   stat
);

  localparam int PTW = mf3_pkg::QPTR_W;
  localparam int LVW = mf3_pkg::QLVL_W;

  mf3_pkg::win_item_t ent_r [mf3_pkg::QDEPTH];
  logic [PTW-1:0]     wptr_r, rptr_r;
  logic [LVW-1:0]     level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= PTW'(wptr_r + PTW'(1));
      end
      if (pop) begin
        rptr_r <= PTW'(rptr_r + PTW'(1));
      end
      level_r <= LVW'(level_r + LVW'(push) - LVW'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_item;
    end
  end

  assign head       = ent_r[rptr_r];
  assign stat.level = level_r;
  assign stat.empty = (level_r == '0);

endmodule

### hw/rtl/mf3_back.sv
module mf3_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 signed_pixels,
  input  mf3_pkg::q_status_t   q_stat,
  input  mf3_pkg::win_item_t   q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  output mf3_pkg::out_beat_t   out_data,
  input  logic                 out_stall
);

  localparam int PW = mf3_pkg::PIX_W;

  typedef struct packed {
    logic [PW-1:0] r2, r3, r4, r5, k6, k7, k8;
    mf3_pkg::tag_t tag;
  } stg_a_t;

  typedef struct packed {
    logic [PW-1:0] r2, r3, r4, k7, k8;
    mf3_pkg::tag_t tag;
  } stg_b_t;

  typedef struct packed {
    logic [PW-1:0] r2, r3, k8;
    mf3_pkg::tag_t tag;
  } stg_c_t;

  // Returns {min, max}
  function automatic logic [2*PW-1:0] cx(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (b < a) ? {b, a} : {a, b};
  endfunction

  logic [PW-1:0] flip;
  logic          en_a, en_b, en_c, en_out;

  logic                a_v_r, b_v_r, c_v_r, out_v_r;
  stg_a_t              a_r, a_nxt;
  stg_b_t              b_r, b_nxt;
  stg_c_t              c_r, c_nxt;
  mf3_pkg::out_beat_t  out_r, out_nxt;

  // Signed order: flip the sign bit and compare unsigned
  assign flip = signed_pixels ? mf3_pkg::PIX_SIGN : '0;

  assign en_out = !out_v_r || !out_stall;
  assign en_c   = !c_v_r || en_out;
  assign en_b   = !b_v_r || en_c;
  assign en_a   = !a_v_r || en_b;
  assign q_pop  = !q_stat.empty && en_a;

  always_comb begin
    logic [PW-1:0] r1, r2, r3, r4, r5, r6;
    r1 = q_head.win[0] ^ flip;
    r2 = q_head.win[1] ^ flip;
    r3 = q_head.win[2] ^ flip;
    r4 = q_head.win[3] ^ flip;
    r5 = q_head.win[4] ^ flip;
    r6 = q_head.win[5] ^ flip;
    {r1, r4} = cx(r1, r4);
    {r2, r5} = cx(r2, r5);
    {r3, r6} = cx(r3, r6);
    {r1, r2} = cx(r1, r2);
    {r1, r3} = cx(r1, r3);
    {r5, r6} = cx(r5, r6);
    {r4, r6} = cx(r4, r6);
    a_nxt.r2  = r2;
    a_nxt.r3  = r3;
    a_nxt.r4  = r4;
    a_nxt.r5  = r5;
    a_nxt.k6  = q_head.win[6] ^ flip;
    a_nxt.k7  = q_head.win[7] ^ flip;
    a_nxt.k8  = q_head.win[8] ^ flip;
    a_nxt.tag = q_head.tag;
  end

  always_comb begin
    logic [PW-1:0] r1, r2, r3, r4, r5;
    r1 = a_r.k6;
    r2 = a_r.r2;
    r3 = a_r.r3;
    r4 = a_r.r4;
    r5 = a_r.r5;
    {r1, r2} = cx(r1, r2);
    {r3, r4} = cx(r3, r4);
    {r1, r3} = cx(r1, r3);
    {r1, r5} = cx(r1, r5);
    {r4, r5} = cx(r4, r5);
    {r2, r5} = cx(r2, r5);
    b_nxt.r2  = r2;
    b_nxt.r3  = r3;
    b_nxt.r4  = r4;
    b_nxt.k7  = a_r.k7;
    b_nxt.k8  = a_r.k8;
    b_nxt.tag = a_r.tag;
  end

  always_comb begin
    logic [PW-1:0] r1, r2, r3, r4;
    r1 = b_r.k7;
    r2 = b_r.r2;
    r3 = b_r.r3;
    r4 = b_r.r4;
    {r1, r2} = cx(r1, r2);
    {r3, r4} = cx(r3, r4);
    {r1, r3} = cx(r1, r3);
    {r2, r4} = cx(r2, r4);
    c_nxt.r2  = r2;
    c_nxt.r3  = r3;
    c_nxt.k8  = b_r.k8;
    c_nxt.tag = b_r.tag;
  end

  always_comb begin
    logic [PW-1:0] r1, r2, r3;
    r1 = c_r.k8;
    r2 = c_r.r2;
    r3 = c_r.r3;
    {r2, r3} = cx(r2, r3);
    {r1, r3} = cx(r1, r3);
    {r1, r2} = cx(r1, r2);
    out_nxt.median     = r2 ^ flip;
    out_nxt.center_row = c_r.tag.center_row;
    out_nxt.center_col = c_r.tag.center_col;
    out_nxt.frame_end  = c_r.tag.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en_a) begin
        a_v_r <= !q_stat.empty;
      end
      if (en_b) begin
        b_v_r <= a_v_r;
      end
      if (en_c) begin
        c_v_r <= b_v_r;
      end
      if (en_out) begin
        out_v_r <= c_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_r <= a_nxt;
    end
    if (en_b) begin
      b_r <= b_nxt;
    end
    if (en_c) begin
      c_r <= c_nxt;
    end
    if (en_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/median_filter_3x3_stream.sv
// Streaming 3x3 median filter for raster-order 16-bit pixels.
// Input channel in_valid/in_stall/in_data carries one pixel per beat, with
// frame_start set on the first pixel of a frame (restarts row and column).
// Output channel out_valid/out_stall/out_data carries one median per pixel
// at row >= 2 and column >= 2, tagged with the centre row and column;
// frame_end marks the last median of a frame. Border pixels give no beat.
// cfg_we/cfg_idx/cfg_wdata write line_width, frame_height, signed_pixels;
// write them only while the filter is idle.
// Throughput: one pixel per clock while in_stall is low. The line stores are one dual-ported RAM
// read and written once per pixel; the median network is four pipeline
// stages of compare-exchange cells.
// A median passes the front stage register, the queue and the a, b, c and out pipeline registers.
// A 4-entry queue separates the line-store front from the median pipeline;
// when out_stall holds the pipeline, the queue fills and in_stall rises
// once the queue and the front stage together hold 4 items.
// Reset: counters clear, registers return to 640 x 480 unsigned, no output
// beat is pending. Line stores are not cleared; no median uses an entry
// before it is written.
module median_filter_3x3_stream (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  mf3_pkg::in_beat_t                       in_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output mf3_pkg::out_beat_t                      out_data,
  input  logic                                    cfg_we,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]           cfg_idx,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

  mf3_pkg::cfg_t       cfg_r;
  mf3_pkg::q_status_t  q_stat;
  mf3_pkg::win_item_t  q_item;
  mf3_pkg::win_item_t  q_head;
  logic                q_push;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width    <= mf3_pkg::LW_W'(640);
      cfg_r.frame_height  <= mf3_pkg::FH_W'(480);
      cfg_r.signed_pixels <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mf3_pkg::CFG_LINE_WIDTH:    cfg_r.line_width   <= cfg_wdata[mf3_pkg::LW_W-1:0];
        mf3_pkg::CFG_FRAME_HEIGHT:  cfg_r.frame_height <= cfg_wdata[mf3_pkg::FH_W-1:0];
        mf3_pkg::CFG_SIGNED_PIXELS: cfg_r.signed_pixels <= cfg_wdata[0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  mf3_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  mf3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  mf3_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .signed_pixels (cfg_r.signed_pixels),
    .q_stat        (q_stat),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_stall     (out_stall)
  );

  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_stat.level < mf3_pkg::QLVL_W'(mf3_pkg::QDEPTH)) || q_pop)
    else $error("queue push while full");

  a_q_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.level == mf3_pkg::QLVL_W'(mf3_pkg::QDEPTH)) |-> in_stall)
    else $error("input taken while queue full");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat right after reset");

endmodule
